// ----- hw/rtl/rkpd_pkg.sv -----
// shared types and constants for the key pair derivation block
`default_nettype none
package rkpd_pkg;

  localparam int LimW  = 14;
  localparam int WordW = 27;
  localparam int StatW = 2;
  localparam int CoefW = WordW + 1;

  localparam logic [LimW-1:0] LIMIT_BOUND = LimW'(10000);
  localparam logic [LimW-1:0] LIMIT_LOW   = LimW'(11);

  localparam logic [StatW-1:0] ST_OK    = StatW'(0);
  localparam logic [StatW-1:0] ST_RANGE = StatW'(1);
  localparam logic [StatW-1:0] ST_NOEXP = StatW'(2);

  // divider operand selection
  typedef enum logic [1:0] {
    DIV_K_BY_D,
    DIV_X_BY_Y,
    DIV_PROD_BY_X
  } div_sel_t;

  // result kind written to the output register
  typedef enum logic [1:0] {
    RES_NONE,
    RES_OK,
    RES_RANGE,
    RES_NOEXP
  } res_kind_t;

  typedef struct packed {
    logic      load_in;
    logic      prime_init;
    logic      prime_sel;
    logic      d_inc;
    logic      k_dec;
    logic      store_prime;
    logic      div_start;
    div_sel_t  div_sel;
    logic      gcd_init;
    logic      gcd_step;
    logic      lcm_store;
    logic      e_init;
    logic      e_inc;
    logic      e_load;
    logic      inv_init;
    logic      inv_q;
    logic      inv_upd;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    logic range_bad;
    logic trial_done;
    logic div_done;
    logic rem_zero;
    logic y_zero;
    logic x_one;
    logic lcm_small;
    logic e_ge_l;
  } sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rkpd_div.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none
module rkpd_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [rkpd_pkg::WordW-1:0] dividend,
  input  wire logic [rkpd_pkg::WordW-1:0] divisor,
  output logic                            done,
  output logic [rkpd_pkg::WordW-1:0]      quot,
  output logic [rkpd_pkg::WordW-1:0]      rem
);

  localparam int CntW = $clog2(rkpd_pkg::WordW);

  logic                       busy_r;
  logic                       done_r;
  logic [CntW-1:0]            cnt_r;
  logic [rkpd_pkg::WordW-1:0] rem_r;
  logic [rkpd_pkg::WordW-1:0] quo_r;
  logic [rkpd_pkg::WordW-1:0] dvs_r;
  logic [rkpd_pkg::WordW:0]   trial;
  logic                       ge;

  // shift in next dividend bit and try subtract
  always_comb begin
    trial = {rem_r, quo_r[rkpd_pkg::WordW-1]};
    ge    = (trial >= {1'b0, dvs_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CntW'(rkpd_pkg::WordW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CntW'(1);
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rkpd_pkg::WordW'(trial - {1'b0, dvs_r});
      end else begin
        rem_r <= trial[rkpd_pkg::WordW-1:0];
      end
      quo_r <= {quo_r[rkpd_pkg::WordW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// ----- hw/rtl/rkpd_dp.sv -----
// datapath: operand registers, shared divider, output registers
`default_nettype none
module rkpd_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rkpd_pkg::cmd_t              cmd,
  output rkpd_pkg::sts_t                   sts,
  input  wire logic [rkpd_pkg::LimW-1:0]   first_limit,
  input  wire logic [rkpd_pkg::LimW-1:0]   second_limit,
  output logic [rkpd_pkg::WordW-1:0]       public_exponent,
  output logic [rkpd_pkg::WordW-1:0]       private_exponent,
  output logic [rkpd_pkg::WordW-1:0]       modulus,
  output logic [rkpd_pkg::StatW-1:0]       status
);

  localparam int LimW  = rkpd_pkg::LimW;
  localparam int WordW = rkpd_pkg::WordW;
  localparam int CoefW = rkpd_pkg::CoefW;

  logic [LimW-1:0]         a_r, b_r;
  logic [LimW-1:0]         k_r, d_r;
  logic [LimW-1:0]         p_r, q_r;
  logic [WordW-1:0]        x_r, y_r;
  logic [WordW-1:0]        l_r, e_r, qt_r;
  logic signed [CoefW-1:0] t0_r, t1_r;
  logic [WordW-1:0]        e_out_r, d_out_r, n_out_r;
  logic [rkpd_pkg::StatW-1:0] st_out_r;

  logic [WordW-1:0]        dvd, dvs, quot, rem;
  logic                    div_done;
  logic [2*LimW-1:0]       dd_sq;
  logic [2*LimW-1:0]       pq_prod;
  logic [2*LimW-1:0]       nm_prod;
  logic signed [CoefW-1:0] qt_prod;
  logic signed [CoefW-1:0] t_new;
  logic signed [CoefW-1:0] t_fix;

  // arithmetic helpers, coefficient product kept to its low bits
  always_comb begin
    dd_sq   = (2*LimW)'(d_r) * (2*LimW)'(d_r);
    pq_prod = (2*LimW)'(p_r - LimW'(1)) * (2*LimW)'(q_r - LimW'(1));
    nm_prod = (2*LimW)'(p_r) * (2*LimW)'(q_r);
    qt_prod = $signed({1'b0, qt_r}) * t1_r;
    t_new   = t0_r - qt_prod;
    t_fix   = t0_r[CoefW-1] ? (t0_r + $signed({1'b0, l_r})) : t0_r;
  end

  // divider operand select
  always_comb begin
    case (cmd.div_sel)
      rkpd_pkg::DIV_K_BY_D: begin
        dvd = WordW'(k_r);
        dvs = WordW'(d_r);
      end
      rkpd_pkg::DIV_X_BY_Y: begin
        dvd = x_r;
        dvs = y_r;
      end
      rkpd_pkg::DIV_PROD_BY_X: begin
        dvd = WordW'(pq_prod);
        dvs = x_r;
      end
      default: begin
        dvd = x_r;
        dvs = y_r;
      end
    endcase
  end

  rkpd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  // operand registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a_r <= first_limit;
      b_r <= second_limit;
    end
    if (cmd.prime_init) begin
      k_r <= cmd.prime_sel ? b_r : a_r;
      d_r <= LimW'(2);
    end
    if (cmd.d_inc) begin
      d_r <= d_r + LimW'(1);
    end
    if (cmd.k_dec) begin
      k_r <= k_r - LimW'(1);
      d_r <= LimW'(2);
    end
    if (cmd.store_prime) begin
      if (cmd.prime_sel) begin
        q_r <= k_r;
      end else begin
        p_r <= k_r;
      end
    end
    if (cmd.gcd_init) begin
      x_r <= WordW'(p_r - LimW'(1));
      y_r <= WordW'(q_r - LimW'(1));
    end
    if (cmd.gcd_step || cmd.inv_upd) begin
      x_r <= y_r;
      y_r <= rem;
    end
    if (cmd.lcm_store) begin
      l_r <= quot;
    end
    if (cmd.e_init) begin
      e_r <= WordW'(2);
    end
    if (cmd.e_inc) begin
      e_r <= e_r + WordW'(1);
    end
    if (cmd.e_load || cmd.inv_init) begin
      x_r <= l_r;
      y_r <= e_r;
    end
    if (cmd.inv_init) begin
      t0_r <= '0;
      t1_r <= CoefW'(1);
    end
    if (cmd.inv_q) begin
      qt_r <= quot;
    end
    if (cmd.inv_upd) begin
      t0_r <= t1_r;
      t1_r <= t_new;
    end
  end

  // output registers
  always_ff @(posedge clk) begin
    case (cmd.res_kind)
      rkpd_pkg::RES_OK: begin
        e_out_r  <= e_r;
        d_out_r  <= t_fix[WordW-1:0];
        n_out_r  <= WordW'(nm_prod);
        st_out_r <= rkpd_pkg::ST_OK;
      end
      rkpd_pkg::RES_RANGE: begin
        e_out_r  <= '0;
        d_out_r  <= '0;
        n_out_r  <= '0;
        st_out_r <= rkpd_pkg::ST_RANGE;
      end
      rkpd_pkg::RES_NOEXP: begin
        e_out_r  <= '0;
        d_out_r  <= '0;
        n_out_r  <= '0;
        st_out_r <= rkpd_pkg::ST_NOEXP;
      end
      default: begin
      end
    endcase
  end

  // status to controller
  always_comb begin
    sts.range_bad  = (a_r < rkpd_pkg::LIMIT_LOW) || (a_r >= rkpd_pkg::LIMIT_BOUND) ||
                     (b_r < rkpd_pkg::LIMIT_LOW) || (b_r >= rkpd_pkg::LIMIT_BOUND);
    sts.trial_done = (dd_sq > (2*LimW)'(k_r));
    sts.div_done   = div_done;
    sts.rem_zero   = (rem == '0);
    sts.y_zero     = (y_r == '0);
    sts.x_one      = (x_r == WordW'(1));
    sts.lcm_small  = (l_r <= WordW'(2));
    sts.e_ge_l     = (e_r >= l_r);
  end

  assign public_exponent  = e_out_r;
  assign private_exponent = d_out_r;
  assign modulus          = n_out_r;
  assign status           = st_out_r;

endmodule
`default_nettype wire

// ----- hw/rtl/rkpd_ctrl.sv -----
// controller state machine sequencing the datapath
`default_nettype none
module rkpd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire rkpd_pkg::sts_t sts,
  output rkpd_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_P_INIT, S_P_TEST, S_P_WAIT, S_G_INIT, S_G_TEST, S_G_WAIT,
    S_L_WAIT, S_L_CHK, S_E_LOAD, S_E_TEST, S_E_WAIT, S_I_INIT, S_I_TEST,
    S_I_WAIT, S_I_UPD, S_FIN_OK, S_FIN_RANGE, S_FIN_NOEXP
  } state_t;

  state_t state_r, state_nxt;
  logic   sel_r, sel_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.div_sel   = rkpd_pkg::DIV_X_BY_Y;
    cmd.res_kind  = rkpd_pkg::RES_NONE;
    cmd.prime_sel = sel_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        sel_nxt   = 1'b0;
        state_nxt = sts.range_bad ? S_FIN_RANGE : S_P_INIT;
      end
      S_P_INIT: begin
        cmd.prime_init = 1'b1;
        state_nxt      = S_P_TEST;
      end
      S_P_TEST: begin
        if (sts.trial_done) begin
          cmd.store_prime = 1'b1;
          if (!sel_r) begin
            sel_nxt   = 1'b1;
            state_nxt = S_P_INIT;
          end else begin
            state_nxt = S_G_INIT;
          end
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = rkpd_pkg::DIV_K_BY_D;
          state_nxt     = S_P_WAIT;
        end
      end
      S_P_WAIT: begin
        if (sts.div_done) begin
          cmd.k_dec = sts.rem_zero;
          cmd.d_inc = !sts.rem_zero;
          state_nxt = S_P_TEST;
        end
      end
      S_G_INIT: begin
        cmd.gcd_init = 1'b1;
        state_nxt    = S_G_TEST;
      end
      S_G_TEST: begin
        cmd.div_start = 1'b1;
        if (sts.y_zero) begin
          cmd.div_sel = rkpd_pkg::DIV_PROD_BY_X;
          state_nxt   = S_L_WAIT;
        end else begin
          state_nxt = S_G_WAIT;
        end
      end
      S_G_WAIT: begin
        if (sts.div_done) begin
          cmd.gcd_step = 1'b1;
          state_nxt    = S_G_TEST;
        end
      end
      S_L_WAIT: begin
        if (sts.div_done) begin
          cmd.lcm_store = 1'b1;
          state_nxt     = S_L_CHK;
        end
      end
      S_L_CHK: begin
        if (sts.lcm_small) begin
          state_nxt = S_FIN_NOEXP;
        end else begin
          cmd.e_init = 1'b1;
          state_nxt  = S_E_LOAD;
        end
      end
      S_E_LOAD: begin
        if (sts.e_ge_l) begin
          state_nxt = S_FIN_NOEXP;
        end else begin
          cmd.e_load = 1'b1;
          state_nxt  = S_E_TEST;
        end
      end
      S_E_TEST: begin
        if (sts.y_zero) begin
          if (sts.x_one) begin
            state_nxt = S_I_INIT;
          end else begin
            cmd.e_inc = 1'b1;
            state_nxt = S_E_LOAD;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_E_WAIT;
        end
      end
      S_E_WAIT: begin
        if (sts.div_done) begin
          cmd.gcd_step = 1'b1;
          state_nxt    = S_E_TEST;
        end
      end
      S_I_INIT: begin
        cmd.inv_init = 1'b1;
        state_nxt    = S_I_TEST;
      end
      S_I_TEST: begin
        if (sts.y_zero) begin
          state_nxt = S_FIN_OK;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_I_WAIT;
        end
      end
      S_I_WAIT: begin
        if (sts.div_done) begin
          cmd.inv_q = 1'b1;
          state_nxt = S_I_UPD;
        end
      end
      S_I_UPD: begin
        cmd.inv_upd = 1'b1;
        state_nxt   = S_I_TEST;
      end
      S_FIN_OK, S_FIN_RANGE, S_FIN_NOEXP: begin
        if (out_free) begin
          case (state_r)
            S_FIN_OK:    cmd.res_kind = rkpd_pkg::RES_OK;
            S_FIN_RANGE: cmd.res_kind = rkpd_pkg::RES_RANGE;
            default:     cmd.res_kind = rkpd_pkg::RES_NOEXP;
          endcase
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ----- hw/rtl/rsa_key_pair_derivation.sv -----
// top level: key pair derivation from two prime search limits
// a rejected limit pair goes from the range check straight to the result; otherwise the run is data
// dependent, each trial division or euclid step waiting on the shared serial divider
// throughput: one item at a time; a new transfer is taken once the result is registered
// reset: synchronous active-low rst_n clears controller state, divider and out_valid
`default_nettype none
module rsa_key_pair_derivation (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [rkpd_pkg::LimW-1:0]     in_first_limit,
  input  wire logic [rkpd_pkg::LimW-1:0]     in_second_limit,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [rkpd_pkg::WordW-1:0]         out_public_exponent,
  output logic [rkpd_pkg::WordW-1:0]         out_private_exponent,
  output logic [rkpd_pkg::WordW-1:0]         out_modulus,
  output logic [rkpd_pkg::StatW-1:0]         out_status
);

  rkpd_pkg::cmd_t cmd;
  rkpd_pkg::sts_t sts;

  rkpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rkpd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .first_limit      (in_first_limit),
    .second_limit     (in_second_limit),
    .public_exponent  (out_public_exponent),
    .private_exponent (out_private_exponent),
    .modulus          (out_modulus),
    .status           (out_status)
  );

endmodule
`default_nettype wire
